>>> rtl/flp_pkg.sv
// Shared types and constants for the firewall log field extractor.
// Used by flp_parser, flp_out_reg and firewall_log_field_extractor.
`timescale 1ns / 1ps
`default_nettype none
package flp_pkg;

	// parse phases
	localparam logic [3:0] PH_PAREN  = 4'd0;
	localparam logic [3:0] PH_SP1    = 4'd1;
	localparam logic [3:0] PH_ACTION = 4'd2;
	localparam logic [3:0] PH_COLON  = 4'd3;
	localparam logic [3:0] PH_SP2    = 4'd4;
	localparam logic [3:0] PH_SRC    = 4'd5;
	localparam logic [3:0] PH_GT     = 4'd6;
	localparam logic [3:0] PH_SP3    = 4'd7;
	localparam logic [3:0] PH_DST    = 4'd8;
	localparam logic [3:0] PH_PROTO  = 4'd9;
	localparam logic [3:0] PH_DONE   = 4'd10;
	localparam logic [3:0] PH_HALT   = 4'd11;

	// stop codes that the phase table does not give directly
	localparam logic [3:0] STOP_NONE   = 4'd0;
	localparam logic [3:0] STOP_SP1    = 4'd2;
	localparam logic [3:0] STOP_ACTION = 4'd3;
	localparam logic [3:0] STOP_SP2    = 4'd5;
	localparam logic [3:0] STOP_GT     = 4'd7;
	localparam logic [3:0] STOP_SP3    = 4'd8;

	localparam logic [2:0] SPLIT_DOTS = 3'd4;

	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_P      = 8'h70;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_COLON  = 8'h3a;
	localparam logic [7:0] CH_GT     = 8'h3e;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_I      = 8'h69;
	localparam logic [7:0] CH_NUL    = 8'h00;

	localparam logic [1:0] ACT_NONE  = 2'd0;
	localparam logic [1:0] ACT_PASS  = 2'd1;
	localparam logic [1:0] ACT_BLOCK = 2'd2;

	localparam logic [1:0] PROTO_NONE = 2'd0;
	localparam logic [1:0] PROTO_TCP  = 2'd1;
	localparam logic [1:0] PROTO_UDP  = 2'd2;
	localparam logic [1:0] PROTO_ICMP = 2'd3;

	localparam logic [1:0] FID_SRC_ADDR = 2'd0;
	localparam logic [1:0] FID_DST_ADDR = 2'd2;

	// fields_found bits
	localparam int FM_ACTION   = 0;
	localparam int FM_SRC_ADDR = 1;
	localparam int FM_SRC_PORT = 2;
	localparam int FM_DST_ADDR = 3;
	localparam int FM_DST_PORT = 4;
	localparam int FM_PROTO    = 5;

	typedef struct packed {
		logic       char_valid;
		logic [1:0] field_id;
		logic [7:0] char_code;
		logic       line_done;
		logic [1:0] action_code;
		logic [1:0] protocol_code;
		logic [5:0] fields_found;
		logic [3:0] stop_point;
	} res_t;

endpackage
`default_nettype wire

>>> rtl/firewall_log_field_extractor.sv
// Top level of the firewall log field extractor.
// Instantiates flp_parser and flp_out_reg; depends on flp_pkg.
//
// Input channel: one log line byte per beat (line_byte, line_last) on
// in_valid / in_ready. Output channel: at most one result per byte on
// out_valid / out_ready. A beat gives a result when it carries a field
// byte (char_valid) or is the last byte of the line (line_done with the
// verdict fields); other bytes only move the parser and give no result.
// A byte is first held in the input register; its result is then
// registered in the result register.
// Throughput: one byte per cycle unless in_ready drops (see below), set
// by the combinational parser step between the two registers.
// When the receiver stalls, the result register holds its beat and one
// more byte waits in the input register; in_ready drops only when that
// byte has a result to deliver and the result register is still full.
// Bytes that give no result keep flowing through during a stall.
// Reset: clears both registers and returns the parser to searching for
// the closing parenthesis of a new line.
`timescale 1ns / 1ps
`default_nettype none
module firewall_log_field_extractor (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [7:0]  line_byte,
	input  wire         line_last,
	output logic        out_valid,
	input  wire         out_ready,
	output logic        char_valid,
	output logic [1:0]  field_id,
	output logic [7:0]  char_code,
	output logic        line_done,
	output logic [1:0]  action_code,
	output logic [1:0]  protocol_code,
	output logic [5:0]  fields_found,
	output logic [3:0]  stop_point
);
	import flp_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       has_result;
	logic       slot_free;
	logic       fire;
	res_t       result;
	res_t       out_data;

	// advance the held byte unless its result has nowhere to go
	assign fire     = valid_s1 && (!has_result || slot_free);
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= line_byte;
			last_s1 <= line_last;
		end
	end

	flp_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_s1    (byte_s1),
		.last_s1    (last_s1),
		.fire       (fire),
		.has_result (has_result),
		.result     (result)
	);

	flp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire && has_result),
		.load_data (result),
		.slot_free (slot_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign char_valid    = out_data.char_valid;
	assign field_id      = out_data.field_id;
	assign char_code     = out_data.char_code;
	assign line_done     = out_data.line_done;
	assign action_code   = out_data.action_code;
	assign protocol_code = out_data.protocol_code;
	assign fields_found  = out_data.fields_found;
	assign stop_point    = out_data.stop_point;

endmodule
`default_nettype wire

>>> rtl/flp_parser.sv
// Parse state and one-byte step logic of the log field extractor.
// Depends on flp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module flp_parser (
	input  wire               clk,
	input  wire               arst_n,
	input  wire  [7:0]        byte_s1,
	input  wire               last_s1,
	input  wire               fire,
	output logic              has_result,
	output flp_pkg::res_t     result
);
	import flp_pkg::*;

	logic [3:0] ph_q, ph_d;
	logic [2:0] dot_q, dot_d;
	logic [1:0] act_q, act_d;
	logic [1:0] proto_q, proto_d;
	logic [5:0] mask_q, mask_d;
	logic [3:0] stop_q, stop_d;
	logic       cv;
	logic [1:0] fid;
	logic       dot_step;
	logic [2:0] dot_next;
	logic [1:0] fid_base;
	logic [3:0] sp;

	// field byte handling shared by source and destination
	always_comb begin
		dot_step = (byte_s1 == CH_DOT) && (dot_q < SPLIT_DOTS);
		dot_next = dot_step ? 3'(dot_q + 3'd1) : dot_q;
		fid_base = (ph_q == PH_DST) ? FID_DST_ADDR : FID_SRC_ADDR;
	end

	always_comb begin
		ph_d    = ph_q;
		dot_d   = dot_q;
		act_d   = act_q;
		proto_d = proto_q;
		mask_d  = mask_q;
		stop_d  = stop_q;
		cv      = 1'b0;
		fid     = 2'd0;
		if (byte_s1 == CH_NUL && ph_q <= PH_PROTO) begin
			ph_d   = PH_HALT;
			stop_d = 4'(ph_q + 4'd1);
		end else begin
			unique case (ph_q)
				PH_PAREN: begin
					if (byte_s1 == CH_RPAREN) ph_d = PH_SP1;
				end
				PH_SP1: begin
					if (byte_s1 == CH_SPACE) begin
						ph_d = PH_ACTION;
					end else begin
						ph_d = PH_HALT; stop_d = STOP_SP1;
					end
				end
				PH_ACTION: begin
					if (byte_s1 == CH_P || byte_s1 == CH_B) begin
						act_d = (byte_s1 == CH_P) ? ACT_PASS : ACT_BLOCK;
						mask_d[FM_ACTION] = 1'b1;
						ph_d = PH_COLON;
					end else begin
						ph_d = PH_HALT; stop_d = STOP_ACTION;
					end
				end
				PH_COLON: begin
					if (byte_s1 == CH_COLON) ph_d = PH_SP2;
				end
				PH_SP2: begin
					if (byte_s1 == CH_SPACE) begin
						ph_d = PH_SRC; dot_d = 3'd0;
					end else begin
						ph_d = PH_HALT; stop_d = STOP_SP2;
					end
				end
				PH_SRC, PH_DST: begin
					if ((ph_q == PH_SRC && byte_s1 == CH_SPACE) ||
					    (ph_q == PH_DST && byte_s1 == CH_COLON)) begin
						if (ph_q == PH_SRC) begin
							mask_d[FM_SRC_ADDR] = 1'b1;
							mask_d[FM_SRC_PORT] = (dot_q == SPLIT_DOTS) | mask_q[FM_SRC_PORT];
							ph_d = PH_GT;
						end else begin
							mask_d[FM_DST_ADDR] = 1'b1;
							mask_d[FM_DST_PORT] = (dot_q == SPLIT_DOTS) | mask_q[FM_DST_PORT];
							ph_d = PH_PROTO;
						end
					end else begin
						dot_d = dot_next;
						// drop the dot that splits address from port
						cv  = !(dot_step && dot_next == SPLIT_DOTS);
						fid = fid_base | {1'b0, dot_next == SPLIT_DOTS};
					end
				end
				PH_GT: begin
					if (byte_s1 == CH_GT) begin
						ph_d = PH_SP3;
					end else begin
						ph_d = PH_HALT; stop_d = STOP_GT;
					end
				end
				PH_SP3: begin
					if (byte_s1 == CH_SPACE) begin
						ph_d = PH_DST; dot_d = 3'd0;
					end else begin
						ph_d = PH_HALT; stop_d = STOP_SP3;
					end
				end
				PH_PROTO: begin
					if (byte_s1 != CH_SPACE) begin
						proto_d = (byte_s1 == CH_U) ? PROTO_UDP :
						          (byte_s1 == CH_I) ? PROTO_ICMP : PROTO_TCP;
						mask_d[FM_PROTO] = 1'b1;
						ph_d = PH_DONE;
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		if (ph_d <= PH_PROTO)
			sp = 4'(ph_d + 4'd1);
		else if (ph_d == PH_DONE)
			sp = STOP_NONE;
		else
			sp = stop_d;
	end

	always_comb begin
		has_result           = cv | last_s1;
		result.char_valid    = cv;
		result.field_id      = cv ? fid : 2'd0;
		result.char_code     = cv ? byte_s1 : 8'd0;
		result.line_done     = last_s1;
		result.action_code   = last_s1 ? act_d : ACT_NONE;
		result.protocol_code = last_s1 ? proto_d : PROTO_NONE;
		result.fields_found  = last_s1 ? mask_d : 6'd0;
		result.stop_point    = last_s1 ? sp : STOP_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= PH_PAREN;
			dot_q   <= 3'd0;
			act_q   <= ACT_NONE;
			proto_q <= PROTO_NONE;
			mask_q  <= 6'd0;
			stop_q  <= STOP_NONE;
		end else if (fire) begin
			if (last_s1) begin
				// line finished: back to the start
				ph_q    <= PH_PAREN;
				dot_q   <= 3'd0;
				act_q   <= ACT_NONE;
				proto_q <= PROTO_NONE;
				mask_q  <= 6'd0;
				stop_q  <= STOP_NONE;
			end else begin
				ph_q    <= ph_d;
				dot_q   <= dot_d;
				act_q   <= act_d;
				proto_q <= proto_d;
				mask_q  <= mask_d;
				stop_q  <= stop_d;
			end
		end
	end

	a_stop_only_halted: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q != PH_HALT |-> stop_q == STOP_NONE)
		else $error("stop reason held outside halt");
	a_dot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dot_q <= SPLIT_DOTS)
		else $error("dot count past split");
	a_action_mask: assert property (@(posedge clk) disable iff (!arst_n)
		act_q != ACT_NONE |-> mask_q[FM_ACTION])
		else $error("action seen without mask bit");
	a_proto_done: assert property (@(posedge clk) disable iff (!arst_n)
		proto_q != PROTO_NONE |-> (ph_q == PH_DONE && mask_q[FM_PROTO]))
		else $error("protocol seen outside done phase");

endmodule
`default_nettype wire

>>> rtl/flp_out_reg.sv
// Result register of the log field extractor: holds one result until taken.
// Depends on flp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module flp_out_reg (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               load,
	input  flp_pkg::res_t     load_data,
	output logic              slot_free,
	output logic              out_valid,
	input  wire               out_ready,
	output flp_pkg::res_t     out_data
);
	import flp_pkg::*;

	logic valid_q;
	res_t data_q;

	assign slot_free = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (slot_free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && load) data_q <= load_data;
	end

endmodule
`default_nettype wire

>>> verif/firewall_log_field_extractor_test.sv
// Self-checking testbench for firewall_log_field_extractor.
// Sends log lines one byte per beat, predicts each result beat and checks it.
// Depends on flp_pkg and the firewall_log_field_extractor RTL only.
`timescale 1ns / 1ps
module firewall_log_field_extractor_test;
	import flp_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 200;
	localparam int DRAIN_CYCLES = 10;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] line_byte = 8'h00;
	logic       line_last = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       char_valid;
	logic [1:0] field_id;
	logic [7:0] char_code;
	logic       line_done;
	logic [1:0] action_code;
	logic [1:0] protocol_code;
	logic [5:0] fields_found;
	logic [3:0] stop_point;

	firewall_log_field_extractor dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.line_byte(line_byte),
		.line_last(line_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.char_valid(char_valid),
		.field_id(field_id),
		.char_code(char_code),
		.line_done(line_done),
		.action_code(action_code),
		.protocol_code(protocol_code),
		.fields_found(fields_found),
		.stop_point(stop_point)
	);

	// parser copy
	logic [3:0] scan_phase;
	logic [2:0] dot_seen;
	logic [1:0] act_latched;
	logic [1:0] proto_latched;
	logic [5:0] found_mask;
	logic [3:0] halt_code;

	res_t       due_extracts[$];
	logic [7:0] line_q[$];
	int         send_idle_pct = 0;
	int         recv_idle_pct = 0;
	int         hold_requests = 0;
	int         fail_count = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic void clear_scan();
		scan_phase = PH_PAREN;
		dot_seen = '0;
		act_latched = ACT_NONE;
		proto_latched = PROTO_NONE;
		found_mask = '0;
		halt_code = STOP_NONE;
	endfunction

	function automatic void parse_log_byte(input logic [7:0] c, input logic last);
		res_t       r;
		logic       in_field;
		logic       split_dot;
		logic [1:0] base;
		logic [1:0] fid;
		logic       emit;
		in_field = 1'b0;
		split_dot = 1'b0;
		base = FID_SRC_ADDR;
		fid = FID_SRC_ADDR;
		emit = 1'b0;
		r = '0;
		if (c == CH_NUL && scan_phase <= PH_PROTO) begin
			halt_code = scan_phase + 4'd1;
			scan_phase = PH_HALT;
		end else begin
			case (scan_phase)
				PH_PAREN: if (c == CH_RPAREN) scan_phase = PH_SP1;
				PH_SP1: begin
					if (c == CH_SPACE) scan_phase = PH_ACTION;
					else begin
						halt_code = STOP_SP1;
						scan_phase = PH_HALT;
					end
				end
				PH_ACTION: begin
					if (c == CH_P || c == CH_B) begin
						act_latched = (c == CH_P) ? ACT_PASS : ACT_BLOCK;
						found_mask[FM_ACTION] = 1'b1;
						scan_phase = PH_COLON;
					end else begin
						halt_code = STOP_ACTION;
						scan_phase = PH_HALT;
					end
				end
				PH_COLON: if (c == CH_COLON) scan_phase = PH_SP2;
				PH_SP2: begin
					if (c == CH_SPACE) begin
						scan_phase = PH_SRC;
						dot_seen = '0;
					end else begin
						halt_code = STOP_SP2;
						scan_phase = PH_HALT;
					end
				end
				PH_SRC: begin
					if (c == CH_SPACE) begin
						found_mask[FM_SRC_ADDR] = 1'b1;
						if (dot_seen == SPLIT_DOTS) found_mask[FM_SRC_PORT] = 1'b1;
						scan_phase = PH_GT;
					end else begin
						in_field = 1'b1;
						base = FID_SRC_ADDR;
					end
				end
				PH_GT: begin
					if (c == CH_GT) scan_phase = PH_SP3;
					else begin
						halt_code = STOP_GT;
						scan_phase = PH_HALT;
					end
				end
				PH_SP3: begin
					if (c == CH_SPACE) begin
						scan_phase = PH_DST;
						dot_seen = '0;
					end else begin
						halt_code = STOP_SP3;
						scan_phase = PH_HALT;
					end
				end
				PH_DST: begin
					if (c == CH_COLON) begin
						found_mask[FM_DST_ADDR] = 1'b1;
						if (dot_seen == SPLIT_DOTS) found_mask[FM_DST_PORT] = 1'b1;
						scan_phase = PH_PROTO;
					end else begin
						in_field = 1'b1;
						base = FID_DST_ADDR;
					end
				end
				PH_PROTO: begin
					if (c != CH_SPACE) begin
						proto_latched = (c == CH_U) ? PROTO_UDP :
							(c == CH_I) ? PROTO_ICMP : PROTO_TCP;
						found_mask[FM_PROTO] = 1'b1;
						scan_phase = PH_DONE;
					end
				end
				default: ;
			endcase
		end
		if (in_field) begin
			// the splitting dot itself is dropped; later dots belong to the port
			if (c == CH_DOT && dot_seen < SPLIT_DOTS) begin
				dot_seen = dot_seen + 3'd1;
				split_dot = (dot_seen == SPLIT_DOTS);
			end
			emit = !split_dot;
			fid = base + ((dot_seen == SPLIT_DOTS) ? 2'd1 : 2'd0);
		end
		if (!emit && !last) return;
		r.char_valid = emit;
		r.field_id = emit ? fid : 2'd0;
		r.char_code = emit ? c : 8'h00;
		if (last) begin
			r.line_done = 1'b1;
			r.action_code = act_latched;
			r.protocol_code = proto_latched;
			r.fields_found = found_mask;
			r.stop_point = (scan_phase <= PH_PROTO) ? scan_phase + 4'd1 :
				(scan_phase == PH_DONE) ? STOP_NONE : halt_code;
			clear_scan();
		end
		due_extracts.push_back(r);
	endfunction

	task automatic send_beat(input logic [7:0] b, input logic last);
		in_valid <= 1'b1;
		line_byte <= b;
		line_last <= last;
		do @(posedge clk); while (!in_ready);
		parse_log_byte(b, last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic send_line();
		foreach (line_q[i]) send_beat(line_q[i], i == line_q.size() - 1);
		line_q.delete();
	endtask

	function automatic logic [7:0] any_char_but(input logic [7:0] avoid);
		logic [7:0] v;
		do v = 8'($urandom_range(1, 255)); while (v == avoid);
		return v;
	endfunction

	function automatic void add_address(input logic [7:0] term);
		int ndots;
		ndots = ($urandom_range(0, 2) != 0) ? SPLIT_DOTS : $urandom_range(0, 6);
		for (int i = 0; i <= ndots; i++) begin
			repeat ($urandom_range(0, 3)) begin
				// mostly ASCII digits, now and then any nonzero byte but the terminator
				if ($urandom_range(0, 4) != 0) line_q.push_back(8'($urandom_range(8'h30, 8'h39)));
				else line_q.push_back(any_char_but(term));
			end
			if (i < ndots) line_q.push_back(CH_DOT);
		end
	endfunction

	function automatic void build_line();
		int pos;
		line_q.delete();
		repeat ($urandom_range(0, 3)) line_q.push_back(any_char_but(CH_RPAREN));
		line_q.push_back(CH_RPAREN);
		line_q.push_back(CH_SPACE);
		line_q.push_back($urandom_range(0, 1) ? CH_P : CH_B);
		repeat ($urandom_range(0, 3)) line_q.push_back(any_char_but(CH_COLON));
		line_q.push_back(CH_COLON);
		line_q.push_back(CH_SPACE);
		add_address(CH_SPACE);
		line_q.push_back(CH_SPACE);
		line_q.push_back(CH_GT);
		line_q.push_back(CH_SPACE);
		add_address(CH_COLON);
		line_q.push_back(CH_COLON);
		repeat ($urandom_range(0, 2)) line_q.push_back(CH_SPACE);
		case ($urandom_range(0, 3))
			0: line_q.push_back(CH_U);
			1: line_q.push_back(CH_I);
			default: line_q.push_back(any_char_but(CH_SPACE));
		endcase
		repeat ($urandom_range(0, 2)) line_q.push_back(8'($urandom_range(0, 255)));
		pos = $urandom_range(0, line_q.size() - 1);
		case ($urandom_range(0, 9))
			6: line_q[pos] = 8'($urandom_range(0, 255));
			7: line_q = line_q[0:pos];
			8: line_q.insert(pos, CH_NUL);
			9: begin
				line_q.delete();
				repeat ($urandom_range(1, 12)) line_q.push_back(8'($urandom_range(0, 255)));
			end
			default: ;
		endcase
	endfunction

	// complete block line: four-dot source with a 0xFF port, five-dot destination, ICMP
	task automatic test_directed_line();
		line_q = '{CH_RPAREN, CH_SPACE, CH_B, CH_COLON, CH_SPACE,
			CH_DOT, CH_DOT, CH_DOT, CH_DOT, 8'hFF, CH_SPACE, CH_GT, CH_SPACE,
			CH_DOT, CH_DOT, CH_DOT, CH_DOT, CH_DOT, CH_COLON, CH_SPACE, CH_I};
		send_line();
	endtask

	// zero byte as the whole line, then a pass line cut off after its action
	task automatic test_short_lines();
		send_beat(CH_NUL, 1'b1);
		line_q = '{CH_RPAREN, CH_SPACE, CH_P};
		send_line();
	endtask

	task automatic test_random_lines(input int tx_pct, input int rx_pct, input int beats);
		int sent;
		sent = 0;
		send_idle_pct = tx_pct;
		recv_idle_pct = rx_pct;
		while (sent < beats) begin
			build_line();
			sent += line_q.size();
			send_line();
		end
	endtask

	// hold the receiver off while lines keep coming so the input stalls
	task automatic test_stall_fill();
		int sent;
		sent = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_requests++;
		while (sent < 70) begin
			build_line();
			sent += line_q.size();
			send_line();
		end
	endtask

	initial begin : receiver
		int hold_left;
		int holds_done;
		hold_left = 0;
		holds_done = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (holds_done != hold_requests) begin
				holds_done = hold_requests;
				hold_left = HOLD_CYCLES - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	function automatic void check_field(input string name, input int unsigned expv,
		input int unsigned actv);
		if (expv != actv) begin
			$error("%s mismatch: expected %0d, got %0d", name, expv, actv);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (due_extracts.size() == 0) begin
				$error("result beat with nothing expected");
				fail_count++;
			end else begin
				want = due_extracts.pop_front();
				check_field("char_valid", want.char_valid, char_valid);
				check_field("field_id", want.field_id, field_id);
				check_field("char_code", want.char_code, char_code);
				check_field("line_done", want.line_done, line_done);
				check_field("action_code", want.action_code, action_code);
				check_field("protocol_code", want.protocol_code, protocol_code);
				check_field("fields_found", want.fields_found, fields_found);
				check_field("stop_point", want.stop_point, stop_point);
			end
		end
	end

	always @(posedge clk) begin
		int quiet_cycles;
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("firewall_log_field_extractor verification failed");
				$finish;
			end
		end
	end

	initial begin
		clear_scan();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 12;
		recv_idle_pct = 87;
		test_directed_line();
		test_short_lines();
		test_random_lines(12, 87, 200);
		test_random_lines(87, 12, 200);
		test_stall_fill();
		test_random_lines(0, 0, 200);
		in_valid <= 1'b0;
		recv_idle_pct = 0;
		while (due_extracts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("firewall_log_field_extractor verification clean");
		end else begin
			$display("firewall_log_field_extractor verification failed");
		end
		$finish;
	end

endmodule
